// ----- rtl/core/base64_line_wrapping_encoder_unit_defines.svh -----
// Assertion macros used by the back part of the base64 line wrapping encoder.
`ifndef BASE64_LINE_WRAPPING_ENCODER_UNIT_DEFINES_SVH
`define BASE64_LINE_WRAPPING_ENCODER_UNIT_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define B64LW_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define B64LW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/b64lw_pkg.sv -----
// Types, constants and the alphabet function of the base64 line wrapping encoder.
package b64lw_pkg;

   localparam int LINE_COUNT_W = 7;

   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_PAD = 8'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   // One group of four characters, optionally followed by CR LF.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic            crlf;
   } job_type;

   function automatic logic [7:0] b64_sym(input logic [5:0] six);
      logic [7:0] c;
      if (six < 6'd26) begin
         c = 8'h41 + {2'b00, six};
      end else if (six < 6'd52) begin
         c = 8'h61 + {2'b00, six} - 8'd26;
      end else if (six < 6'd62) begin
         c = 8'h30 + {2'b00, six} - 8'd52;
      end else if (six == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/base64_line_wrapping_encoder_unit.sv -----
// A request that completes or ends a group is written into the job queue; the back part then
// loads it into its job register and sends one character per cycle while rsp_ready is high.
// A group has four characters, or six with CR LF.
// Requests are taken every cycle while the two-entry job queue has room.
// Synchronous active-high reset clears the group phase, line count, queue and output stage.
module base64_line_wrapping_encoder_unit #(
   parameter int LINE_CHARS = 76
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64lw_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64lw_pkg::rsp_type rsp_payload
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   b64lw_pkg::job_type push_job, pop_job;

   b64lw_front #(
      .LINE_CHARS(LINE_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b64lw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_job  (push_job),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job)
   );

   b64lw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// ----- rtl/core/b64lw_front.sv -----
// Front part: collects bytes into groups, tracks the line count and builds jobs.
module b64lw_front #(
   parameter int LINE_CHARS = 76
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64lw_pkg::req_type req_payload,
   output logic               push_valid,
   input  logic               push_ready,
   output b64lw_pkg::job_type push_job
);

   localparam logic [b64lw_pkg::LINE_COUNT_W-1:0] LineLimit =
      b64lw_pkg::LINE_COUNT_W'(LINE_CHARS);

   logic [1:0]                         group_phase_ff, group_phase_in;
   logic [b64lw_pkg::LINE_COUNT_W-1:0] line_count_ff, line_count_in;
   logic [7:0]                         pending_ff [2];
   logic [b64lw_pkg::LINE_COUNT_W-1:0] line_next;
   logic [23:0]                        word;
   logic                               accept, full_group, wrap;
   logic [7:0]                         b, a;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign b          = req_payload.data_byte;
   assign a          = pending_ff[0];
   // A phase of three never occurs; it would be handled like two.
   assign full_group = group_phase_ff[1];
   assign word       = {pending_ff[0], pending_ff[1], b};
   assign line_next  = line_count_ff + b64lw_pkg::LINE_COUNT_W'(4);
   assign wrap       = line_next >= LineLimit;
   assign push_valid = req_valid && (full_group || req_payload.final_byte);

   always_comb begin
      push_job = '0;
      if (full_group) begin
         push_job.chars[0] = b64lw_pkg::b64_sym(word[23:18]);
         push_job.chars[1] = b64lw_pkg::b64_sym(word[17:12]);
         push_job.chars[2] = b64lw_pkg::b64_sym(word[11:6]);
         push_job.chars[3] = b64lw_pkg::b64_sym(word[5:0]);
         push_job.crlf     = wrap;
      end else if (group_phase_ff[0]) begin
         push_job.chars[0] = b64lw_pkg::b64_sym(a[7:2]);
         push_job.chars[1] = b64lw_pkg::b64_sym({a[1:0], b[7:4]});
         push_job.chars[2] = b64lw_pkg::b64_sym({b[3:0], 2'b00});
         push_job.chars[3] = b64lw_pkg::CHAR_PAD;
      end else begin
         push_job.chars[0] = b64lw_pkg::b64_sym(b[7:2]);
         push_job.chars[1] = b64lw_pkg::b64_sym({b[1:0], 4'b0000});
         push_job.chars[2] = b64lw_pkg::CHAR_PAD;
         push_job.chars[3] = b64lw_pkg::CHAR_PAD;
      end
   end

   always_comb begin
      group_phase_in = group_phase_ff;
      line_count_in  = line_count_ff;
      if (accept) begin
         if (req_payload.final_byte) begin
            group_phase_in = 2'd0;
            line_count_in  = '0;
         end else if (full_group) begin
            group_phase_in = 2'd0;
            line_count_in  = wrap ? '0 : line_next;
         end else begin
            group_phase_in = group_phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_phase_ff <= 2'd0;
         line_count_ff  <= '0;
      end else begin
         group_phase_ff <= group_phase_in;
         line_count_ff  <= line_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !full_group && !req_payload.final_byte) begin
         pending_ff[group_phase_ff[0]] <= b;
      end
   end

endmodule

// ----- rtl/core/b64lw_queue.sv -----
// Two-entry job queue between the front and back parts.
module b64lw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  b64lw_pkg::job_type push_job,
   output logic               pop_valid,
   input  logic               pop_ready,
   output b64lw_pkg::job_type pop_job
);

   b64lw_pkg::job_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/b64lw_back.sv -----
// Back part: sends job characters, then CR LF if set, one per cycle while rsp_ready.
`include "base64_line_wrapping_encoder_unit_defines.svh"

module b64lw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  b64lw_pkg::job_type pop_job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64lw_pkg::rsp_type rsp_payload
);

   b64lw_pkg::job_type job_ff, job_in;
   logic               busy_ff, busy_in;
   logic [2:0]         idx_ff, idx_in;
   logic               fire, last, done, load;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && rsp_ready;
   assign last      = job_ff.crlf ? (idx_ff == 3'd5) : (idx_ff == 3'd3);
   assign done      = fire && last;
   // The next job loads in the same cycle the previous one hands over its last character.
   assign load      = pop_valid && (!busy_ff || done);
   assign pop_ready = !busy_ff || done;

   always_comb begin
      if (!idx_ff[2]) begin
         rsp_payload.out_char = job_ff.chars[idx_ff[1:0]];
      end else if (idx_ff[0]) begin
         rsp_payload.out_char = b64lw_pkg::CHAR_LF;
      end else begin
         rsp_payload.out_char = b64lw_pkg::CHAR_CR;
      end
      rsp_payload.last_char = last;
   end

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         job_in  = pop_job;
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (done) begin
         busy_in = 1'b0;
         idx_in  = 3'd0;
      end else if (fire) begin
         idx_in  = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   `B64LW_ASSERT(idx_in_group, (busy_ff && !job_ff.crlf) |-> (idx_ff <= 3'd3), "index past group")
   `B64LW_ASSERT(idx_only_busy, (idx_ff != 3'd0) |-> busy_ff, "index moved while idle")
   `B64LW_ASSERT_NEXT(idle_after_drain, done && !pop_valid, !busy_ff, "busy after last char")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the base64 line wrapping encoder unit.
module testbench;

   localparam int LINE_CHARS = 76;
   localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   b64lw_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_ready;
   b64lw_pkg::rsp_type rsp_payload;

   // Encoder state as predicted from the accepted requests.
   logic [7:0] held_first;
   logic [7:0] held_second;
   logic [1:0] held_count;
   logic [6:0] line_fill;

   b64lw_pkg::rsp_type expected_chars[$];
   int                 mismatch_count = 0;
   int                 send_idle_pct = 0;
   int                 sink_stall_pct = 0;

   base64_line_wrapping_encoder_unit #(
      .LINE_CHARS(LINE_CHARS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
      return B64_ALPHABET[sextet];
   endfunction

   task automatic expect_char(input logic [7:0] c, input logic is_last);
      b64lw_pkg::rsp_type e;
      e.out_char  = c;
      e.last_char = is_last;
      expected_chars.push_back(e);
   endtask

   // Works out the characters that one accepted request must produce.
   task automatic encode_request(input b64lw_pkg::req_type r);
      logic [23:0] bits;
      logic        wrap;
      wrap = 1'b0;
      if (held_count >= 2'd2) begin
         bits = {held_first, held_second, r.data_byte};
         line_fill = line_fill + 7'd4;
         wrap = (line_fill >= LINE_CHARS);
         expect_char(sextet_char(bits[23:18]), 1'b0);
         expect_char(sextet_char(bits[17:12]), 1'b0);
         expect_char(sextet_char(bits[11:6]), 1'b0);
         expect_char(sextet_char(bits[5:0]), !wrap);
         if (wrap) begin
            expect_char(b64lw_pkg::CHAR_CR, 1'b0);
            expect_char(b64lw_pkg::CHAR_LF, 1'b1);
            line_fill = '0;
         end
         held_count = 2'd0;
      end else if (r.final_byte) begin
         // The padded group never counts toward the line length.
         if (held_count == 2'd0) begin
            expect_char(sextet_char(r.data_byte[7:2]), 1'b0);
            expect_char(sextet_char({r.data_byte[1:0], 4'b0000}), 1'b0);
            expect_char(b64lw_pkg::CHAR_PAD, 1'b0);
         end else begin
            expect_char(sextet_char(held_first[7:2]), 1'b0);
            expect_char(sextet_char({held_first[1:0], r.data_byte[7:4]}), 1'b0);
            expect_char(sextet_char({r.data_byte[3:0], 2'b00}), 1'b0);
         end
         expect_char(b64lw_pkg::CHAR_PAD, 1'b1);
      end else begin
         if (held_count[0]) begin
            held_second = r.data_byte;
         end else begin
            held_first = r.data_byte;
         end
         held_count = held_count + 2'd1;
      end
      if (r.final_byte) begin
         held_count = 2'd0;
         line_fill  = '0;
      end
   endtask

   task automatic send_request(input logic [7:0] data, input logic is_final);
      b64lw_pkg::req_type r;
      r.data_byte  = data;
      r.final_byte = is_final;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_request(r);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected character %h last %b", rsp_payload.out_char,
                  rsp_payload.last_char);
            end
            mismatch_count++;
         end else begin
            if (rsp_payload.out_char !== expected_chars[0].out_char ||
                  rsp_payload.last_char !== expected_chars[0].last_char) begin
               if (mismatch_count < 10) begin
                  $display("character mismatch: expected %h last %b, got %h last %b",
                     expected_chars[0].out_char, expected_chars[0].last_char,
                     rsp_payload.out_char, rsp_payload.last_char);
               end
               mismatch_count++;
            end
            void'(expected_chars.pop_front());
         end
      end
   end

   task automatic send_message(input int length);
      for (int i = 0; i < length; i++) begin
         send_request(8'($urandom), i == length - 1);
      end
   endtask

   // Remainders of one and two bytes, a final byte that completes a group,
   // and a group followed by a one-byte remainder.
   task automatic test_short_messages();
      send_request(8'h00, 1'b1);
      send_request(8'hff, 1'b1);
      send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b1);
      send_request(8'h4d, 1'b0);
      send_request(8'h61, 1'b0);
      send_request(8'h6e, 1'b1);
      send_request(8'hfc, 1'b0);
      send_request(8'h03, 1'b0);
      send_request(8'h0f, 1'b0);
      send_request(8'hf0, 1'b1);
   endtask

   // Nineteen groups fill a line exactly; the last byte ends the message.
   task automatic test_line_wrap();
      send_message(57);
   endtask

   // Mostly short messages, now and then one of 56 to 64 bytes that may wrap a line.
   task automatic test_random_messages(input int idle_pct, input int stall_pct,
         input int byte_budget);
      int sent;
      int length;
      send_idle_pct  = idle_pct;
      sink_stall_pct = stall_pct;
      sent = 0;
      while (sent < byte_budget) begin
         length = ($urandom_range(3) == 0) ? $urandom_range(56, 64) : $urandom_range(1, 10);
         send_message(length);
         sent += length;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      held_first  = '0;
      held_second = '0;
      held_count  = '0;
      line_fill   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_messages();
      test_line_wrap();
      test_random_messages(0, 0, 10);
      test_random_messages(51, 0, 10);
      test_random_messages(0, 51, 10);
      test_random_messages(34, 34, 10);
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
